### src/vms_pkg.sv
// ----------------------------------------------------------------------------
// vms_pkg
// Shared types and constants for the ventilation mode scheduler.
// ----------------------------------------------------------------------------
package vms_pkg;

	localparam int HOUR_W     = 5;
	localparam int MIN_W      = 6;
	localparam int LEN_W      = 11;
	localparam int CFG_DATA_W = 11;
	// whole hours of a window length: at most 2047 / 60 = 34
	localparam int LEN_HR_W   = 6;
	localparam int END_HR_W   = 7;

	// len / 60 == (len * 2185) >> 17 for every 11-bit len
	localparam int RECIP_60_W  = 12;
	localparam int RECIP_60    = 2185;
	localparam int RECIP_SHIFT = 17;
	localparam int PROD_W      = LEN_W + RECIP_60_W;

	// register map
	localparam int REG_AUTO_VENT = 0;
	localparam int REG_AUTO_HEAT = 1;
	localparam int REG_WIN_BASE  = 2;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_HEAT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_OFF  = 2'd1,
		OP_ON   = 2'd2,
		OP_HEAT = 2'd3
	} op_t;

endpackage

### src/vms_window_bank.sv
// ----------------------------------------------------------------------------
// vms_window_bank
// Work window registers and time match. A length is split into whole hours
// and leftover minutes when written, so the match is a few narrow compares.
// ----------------------------------------------------------------------------
module vms_window_bank
	import vms_pkg::*;
#(
	parameter int NUM_WINDOWS = 3,
	parameter int IDX_W       = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [HOUR_W-1:0]     hour_now,
	input  logic [MIN_W-1:0]      minute_now,
	output logic                  hit
);

	logic [NUM_WINDOWS-1:0] win_hit;

	// length split of the incoming write data
	logic [LEN_W-1:0]    wr_len;
	logic [PROD_W-1:0]   wr_prod;
	logic [LEN_HR_W-1:0] wr_hr;
	logic [LEN_W-1:0]    wr_rem;
	logic [MIN_W-1:0]    wr_min;

	assign wr_len  = cfg_data[LEN_W-1:0];
	assign wr_prod = PROD_W'(wr_len) * PROD_W'(RECIP_60);
	assign wr_hr   = wr_prod[RECIP_SHIFT +: LEN_HR_W];
	// len - 60*h, with 60*h = 64*h - 4*h
	assign wr_rem  = wr_len - (LEN_W'(wr_hr) << 6) + (LEN_W'(wr_hr) << 2);
	assign wr_min  = wr_rem[MIN_W-1:0];

	for (genvar k = 0; k < NUM_WINDOWS; k++) begin : g_win
		logic [HOUR_W-1:0]   start_q;
		logic [LEN_HR_W-1:0] len_hr_q;
		logic [MIN_W-1:0]    len_min_q;
		logic [END_HR_W-1:0] end_hr;
		logic [END_HR_W-1:0] hr_ext;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				start_q   <= '0;
				len_hr_q  <= '0;
				len_min_q <= '0;
			end else if (cfg_we) begin
				if (cfg_index == IDX_W'(REG_WIN_BASE + 2 * k))
					start_q <= cfg_data[HOUR_W-1:0];
				if (cfg_index == IDX_W'(REG_WIN_BASE + 2 * k + 1)) begin
					len_hr_q  <= wr_hr;
					len_min_q <= wr_min;
				end
			end
		end

		assign end_hr = END_HR_W'(start_q) + END_HR_W'(len_hr_q);
		assign hr_ext = END_HR_W'(hour_now);

		// zero leftover minutes makes the equal-hour term false on its own
		assign win_hit[k] = (hour_now >= start_q) &&
		                    ((hr_ext < end_hr) ||
		                     ((hr_ext == end_hr) && (minute_now < len_min_q)));
	end

	assign hit = |win_hit;

endmodule

### src/vent_mode_scheduler.sv
// ----------------------------------------------------------------------------
// vent_mode_scheduler
// Ventilation mode selector: button command, daily work windows, trip/fault.
// A word accepted goes to the input register, then to the state/result register.
// Throughput: one word per cycle while the receiver takes results; the mode update
// is one pass of logic between the input register and the state/result register.
// Reset: asynchronous, mode off, fault and cooling clear, auto permitted,
// all configuration registers zero, both channels empty.
// ----------------------------------------------------------------------------
module vent_mode_scheduler
	import vms_pkg::*;
#(
	parameter int NUM_WINDOWS = 3
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [$clog2(REG_WIN_BASE+2*NUM_WINDOWS)-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]                    cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [1:0]                               opcode,
	input  logic [HOUR_W-1:0]                        hour_now,
	input  logic [MIN_W-1:0]                         minute_now,
	input  logic                                     trip_event,
	input  logic                                     reset_request,
	input  logic                                     cooling_clear,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [1:0]                               mode_now,
	output logic                                     cooling_needed,
	output logic                                     fault_active,
	output logic                                     auto_permitted,
	output logic                                     in_work_window
);

	localparam int NUM_REGS = REG_WIN_BASE + 2 * NUM_WINDOWS;
	localparam int IDX_W    = $clog2(NUM_REGS);

	// input register
	logic              valid_s1;
	op_t               op_s1;
	logic [HOUR_W-1:0] hour_s1;
	logic [MIN_W-1:0]  min_s1;
	logic              trip_s1;
	logic              rst_s1;
	logic              cclr_s1;

	// state, which is also the result word
	mode_t mode_q;
	mode_t last_q;
	logic  cool_q;
	logic  fault_q;
	logic  allow_q;
	logic  work_q;
	logic  out_valid_q;

	logic auto_vent_q;
	logic auto_heat_q;

	logic  advance;
	logic  hit;
	mode_t mode_d;
	mode_t last_d;
	mode_t manual;
	mode_t target;
	logic  cool_d;
	logic  fault_d;
	logic  allow_d;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op_t'(opcode);
			hour_s1 <= hour_now;
			min_s1  <= minute_now;
			trip_s1 <= trip_event;
			rst_s1  <= reset_request;
			cclr_s1 <= cooling_clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_vent_q <= 1'b0;
			auto_heat_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == IDX_W'(REG_AUTO_VENT))
				auto_vent_q <= cfg_data[0];
			if (cfg_index == IDX_W'(REG_AUTO_HEAT))
				auto_heat_q <= cfg_data[0];
		end
	end

	vms_window_bank #(
		.NUM_WINDOWS (NUM_WINDOWS),
		.IDX_W       (IDX_W)
	) u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.hour_now   (hour_s1),
		.minute_now (min_s1),
		.hit        (hit)
	);

	// cooling clear, then fault reset, then trip or mode update
	always_comb begin
		mode_d  = mode_q;
		last_d  = last_q;
		cool_d  = cool_q & ~cclr_s1;
		fault_d = fault_q & ~rst_s1;
		allow_d = allow_q | rst_s1;
		manual  = mode_q;
		target  = mode_q;
		if (trip_s1) begin
			fault_d = 1'b1;
			cool_d  = 1'b1;
			mode_d  = MODE_OFF;
			allow_d = 1'b0;
		end else if (!fault_d) begin
			case (op_s1)
				OP_OFF: begin
					if (mode_q == MODE_HEAT)
						cool_d = 1'b1;
					manual = MODE_OFF;
				end
				OP_ON:   manual = MODE_ON;
				OP_HEAT: manual = MODE_HEAT;
				default: manual = mode_q;
			endcase

			if (manual != mode_q) begin
				mode_d = manual;
			end else begin
				if (auto_vent_q && allow_d) begin
					if (hit) begin
						target = auto_heat_q ? MODE_HEAT : MODE_ON;
					end else begin
						if (mode_q == MODE_HEAT)
							cool_d = 1'b1;
						target = MODE_OFF;
					end
				end
				// auto acts only on a change of its own target
				if (target != last_q)
					mode_d = target;
				last_d = target;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			last_q      <= MODE_OFF;
			cool_q      <= 1'b0;
			fault_q     <= 1'b0;
			allow_q     <= 1'b1;
			work_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q  <= mode_d;
				last_q  <= last_d;
				cool_q  <= cool_d;
				fault_q <= fault_d;
				allow_q <= allow_d;
				work_q  <= hit;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode_now       = mode_q;
	assign cooling_needed = cool_q;
	assign fault_active   = fault_q;
	assign auto_permitted = allow_q;
	assign in_work_window = work_q;

endmodule

### src/vms_checker.sv
// ----------------------------------------------------------------------------
// vms_checker
// Port-level checks for the ventilation mode scheduler, bound to the top.
// ----------------------------------------------------------------------------
module vms_checker
	import vms_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] mode_now,
	input logic       cooling_needed,
	input logic       fault_active,
	input logic       auto_permitted,
	input logic       in_work_window
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode_now) &&
		$stable(cooling_needed) && $stable(fault_active) &&
		$stable(auto_permitted) && $stable(in_work_window))
		else $error("result word changed while stalled");

	a_fault_off: assert property (@(posedge clk) disable iff (!arst_n)
		fault_active |-> mode_now == MODE_OFF)
		else $error("mode not off during fault");

	a_fault_no_auto: assert property (@(posedge clk) disable iff (!arst_n)
		fault_active |-> !auto_permitted)
		else $error("auto permitted during fault");

	// a trip always raises the cooling request with the fault
	a_trip_cool: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fault_active) |-> cooling_needed)
		else $error("fault raised without cooling request");

endmodule

bind vent_mode_scheduler vms_checker u_vms_checker (.*);

### test/tb_vent_mode_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vent_mode_scheduler
// Self-checking bench for the ventilation mode scheduler. A scoreboard keeps
// its own copy of the mode, fault and cooling state and of the window
// registers, predicts the status word for every accepted tick and checks it
// against the returned words in order. A directed opening covers the window
// edges, every button command, trip/reset/cooling-clear and out-of-range
// times. Random phases follow, each with new register settings and one of four
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_vent_mode_scheduler;
	import vms_pkg::*;

	localparam int N_WIN = 3;
	localparam int IDX_W = $clog2(REG_WIN_BASE + 2 * N_WIN);

	typedef struct packed {
		mode_t mode;
		logic  cooling;
		logic  fault;
		logic  permit;
		logic  work;
	} status_t;

	typedef struct packed {
		logic                         av;
		logic                         ah;
		logic [N_WIN-1:0][HOUR_W-1:0] start;
		logic [N_WIN-1:0][LEN_W-1:0]  len;
	} cfg_set_t;

	class mode_scoreboard;
		bit             auto_vent;
		bit             auto_heat;
		int             win_start[N_WIN];
		int             win_len[N_WIN];
		mode_t          mode;
		mode_t          last_target;
		bit             cooling;
		bit             fault;
		bit             permit;
		status_t        status_q[$];
		int             mismatches;

		function new();
			int k;
			auto_vent   = 0;
			auto_heat   = 0;
			for (k = 0; k < N_WIN; k++) begin
				win_start[k] = 0;
				win_len[k]   = 0;
			end
			mode        = MODE_OFF;
			last_target = MODE_OFF;
			cooling     = 0;
			fault       = 0;
			permit      = 1;
			mismatches  = 0;
		endfunction

		function void write_reg(int idx, int data);
			int k;
			if (idx == REG_AUTO_VENT) begin
				auto_vent = ((data & 1) != 0);
			end else if (idx == REG_AUTO_HEAT) begin
				auto_heat = ((data & 1) != 0);
			end else if (idx >= REG_WIN_BASE && idx < REG_WIN_BASE + 2 * N_WIN) begin
				k = (idx - REG_WIN_BASE) / 2;
				if (((idx - REG_WIN_BASE) & 1) == 0)
					win_start[k] = data & 'h1F;
				else
					win_len[k] = data & 'h7FF;
			end
		endfunction

		// hour-granular compare: minutes only matter in the last, partial hour
		function bit window_hit(int start, int len, int hr, int mn);
			if (len == 0 || hr < start)
				return 0;
			if (hr < start + len / 60)
				return 1;
			return (hr == start + len / 60) && (mn < len % 60);
		endfunction

		function void note_word(op_t op, int hr, int mn, bit trip, bit rst, bit clr);
			bit      work;
			mode_t   manual;
			mode_t   target;
			status_t s;
			int      k;
			work = 0;
			for (k = 0; k < N_WIN; k++)
				if (window_hit(win_start[k], win_len[k], hr, mn))
					work = 1;
			if (clr)
				cooling = 0;
			if (rst) begin
				fault  = 0;
				permit = 1;
			end
			if (trip) begin
				fault   = 1;
				cooling = 1;
				mode    = MODE_OFF;
				permit  = 0;
			end else if (!fault) begin
				manual = mode;
				case (op)
					OP_OFF: begin
						if (mode == MODE_HEAT)
							cooling = 1;
						manual = MODE_OFF;
					end
					OP_ON:   manual = MODE_ON;
					OP_HEAT: manual = MODE_HEAT;
					default: ;
				endcase
				if (manual != mode) begin
					mode = manual;
				end else begin
					target = mode;
					if (auto_vent && permit) begin
						if (work) begin
							target = auto_heat ? MODE_HEAT : MODE_ON;
						end else begin
							if (mode == MODE_HEAT)
								cooling = 1;
							target = MODE_OFF;
						end
					end
					// auto acts only on a change of its own target
					if (target != last_target)
						mode = target;
					last_target = target;
				end
			end
			s.mode    = mode;
			s.cooling = cooling;
			s.fault   = fault;
			s.permit  = permit;
			s.work    = work;
			status_q.push_back(s);
		endfunction

		function void check_word(status_t got);
			status_t exp_s;
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: status word with none expected: ",
						"mode=%0d cool=%0b flt=%0b perm=%0b win=%0b"},
						$time, got.mode, got.cooling, got.fault, got.permit,
						got.work);
				return;
			end
			exp_s = status_q.pop_front();
			if (got.mode !== exp_s.mode || got.cooling !== exp_s.cooling ||
					got.fault !== exp_s.fault || got.permit !== exp_s.permit ||
					got.work !== exp_s.work) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: status mismatch: ",
						"exp mode=%0d cool=%0b flt=%0b perm=%0b win=%0b, ",
						"got mode=%0d cool=%0b flt=%0b perm=%0b win=%0b"},
						$time, exp_s.mode, exp_s.cooling, exp_s.fault, exp_s.permit,
						exp_s.work, got.mode, got.cooling, got.fault, got.permit,
						got.work);
			end
		endfunction
	endclass

	logic                  clk            = 0;
	logic                  arst_n         = 0;
	logic                  cfg_we         = 0;
	logic [IDX_W-1:0]      cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;
	logic                  in_valid       = 0;
	logic                  in_ready;
	logic [1:0]            opcode         = OP_NONE;
	logic [HOUR_W-1:0]     hour_now       = '0;
	logic [MIN_W-1:0]      minute_now     = '0;
	logic                  trip_event     = 0;
	logic                  reset_request  = 0;
	logic                  cooling_clear  = 0;
	logic                  out_valid;
	logic                  out_ready      = 0;
	logic [1:0]            mode_now;
	logic                  cooling_needed;
	logic                  fault_active;
	logic                  auto_permitted;
	logic                  in_work_window;

	int             idle_pct  = 0;
	int             stall_pct = 0;
	mode_scoreboard sb;

	vent_mode_scheduler #(
		.NUM_WINDOWS(N_WIN)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.hour_now      (hour_now),
		.minute_now    (minute_now),
		.trip_event    (trip_event),
		.reset_request (reset_request),
		.cooling_clear (cooling_clear),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mode_now      (mode_now),
		.cooling_needed(cooling_needed),
		.fault_active  (fault_active),
		.auto_permitted(auto_permitted),
		.in_work_window(in_work_window)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// everything is driven by NBA, so these reads see pre-edge values
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (cfg_we)
				sb.write_reg(int'(cfg_index), int'(cfg_data));
			if (in_valid && in_ready)
				sb.note_word(op_t'(opcode), int'(hour_now), int'(minute_now),
					trip_event, reset_request, cooling_clear);
			if (out_valid && out_ready)
				sb.check_word({mode_t'(mode_now), cooling_needed, fault_active,
					auto_permitted, in_work_window});
		end
	end

	task automatic send_word(op_t op, int hr, int mn, bit trip, bit rst, bit clr);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid      <= 1;
		opcode        <= op;
		hour_now      <= HOUR_W'(hr);
		minute_now    <= MIN_W'(mn);
		trip_event    <= trip;
		reset_request <= rst;
		cooling_clear <= clr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// wait until every expected status word is back and the pipe is empty
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(cfg_set_t c);
		int k;
		cfg_we    <= 1;
		cfg_index <= IDX_W'(REG_AUTO_VENT);
		cfg_data  <= CFG_DATA_W'(c.av);
		@(posedge clk);
		cfg_index <= IDX_W'(REG_AUTO_HEAT);
		cfg_data  <= CFG_DATA_W'(c.ah);
		@(posedge clk);
		for (k = 0; k < N_WIN; k++) begin
			cfg_index <= IDX_W'(REG_WIN_BASE + 2 * k);
			cfg_data  <= CFG_DATA_W'(c.start[k]);
			@(posedge clk);
			cfg_index <= IDX_W'(REG_WIN_BASE + 2 * k + 1);
			cfg_data  <= CFG_DATA_W'(c.len[k]);
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	function automatic cfg_set_t pick_config(int phase);
		cfg_set_t c;
		int       k;
		c.av = ($urandom_range(0, 3) != 0);
		c.ah = 1'($urandom_range(0, 1));
		for (k = 0; k < N_WIN; k++) begin
			c.start[k] = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom_range(24, 31))
				: HOUR_W'($urandom_range(0, 23));
			case ($urandom_range(0, 7))
				0:       c.len[k] = 0;
				1:       c.len[k] = LEN_W'(60 * $urandom_range(1, 23));
				2:       c.len[k] = LEN_W'($urandom_range(1439, 2047));
				default: c.len[k] = LEN_W'($urandom_range(1, 600));
			endcase
		end
		if (phase == 0) begin
			c.av       = 1;
			c.ah       = 1;
			c.start[0] = 31;
			c.len[0]   = 2047;
			c.start[1] = 23;
			c.len[1]   = 1439;
			c.start[2] = 0;
			c.len[2]   = 1439;
		end else if (phase == 1) begin
			c.av    = 1;
			c.ah    = 0;
			c.start = '0;
			c.len   = '0;
		end else if (phase == 6) begin
			c.av = 0;
		end
		return c;
	endfunction

	task automatic random_word(cfg_set_t c);
		op_t op;
		int  hr;
		int  mn;
		int  t;
		int  k;
		int  sel;
		op  = ($urandom_range(0, 9) < 5) ? OP_NONE : op_t'($urandom_range(1, 3));
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			hr = $urandom_range(0, 31);
			mn = $urandom_range(0, 63);
		end else if (sel <= 8) begin
			// land on or next to a window start or end
			k  = $urandom_range(0, N_WIN - 1);
			t  = int'(c.start[k]) * 60 + ($urandom_range(0, 1) ? int'(c.len[k]) : 0)
				+ $urandom_range(0, 2) - 1;
			if (t < 0)
				t = 0;
			hr = (t / 60) % 32;
			mn = t % 60;
		end else begin
			hr = $urandom_range(0, 23);
			mn = $urandom_range(0, 59);
		end
		send_word(op, hr, mn, $urandom_range(0, 39) == 0, $urandom_range(0, 14) == 0,
			$urandom_range(0, 7) == 0);
	endtask

	initial begin
		cfg_set_t cfg;
		int       p;
		int       i;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// registers still at reset: auto off, all windows empty
		send_word(OP_NONE, 0, 0, 0, 0, 0);
		send_word(OP_OFF, 0, 0, 0, 0, 0);
		send_word(OP_ON, 23, 59, 0, 0, 0);
		drain();

		cfg.av       = 1;
		cfg.ah       = 0;
		cfg.start[0] = 8;
		cfg.len[0]   = 90;
		cfg.start[1] = 23;
		cfg.len[1]   = 60;
		cfg.start[2] = 5;
		cfg.len[2]   = 0;
		load_config(cfg);
		send_word(OP_OFF, 7, 59, 0, 0, 0);
		send_word(OP_NONE, 8, 0, 0, 0, 0);
		send_word(OP_NONE, 9, 29, 0, 0, 0);
		send_word(OP_NONE, 9, 30, 0, 0, 0);
		send_word(OP_NONE, 5, 0, 0, 0, 0);
		send_word(OP_HEAT, 12, 0, 0, 0, 0);
		send_word(OP_NONE, 12, 1, 0, 0, 0);
		send_word(OP_OFF, 12, 2, 0, 0, 0);
		send_word(OP_NONE, 23, 0, 0, 0, 1);
		send_word(OP_NONE, 31, 63, 0, 0, 0);
		send_word(OP_HEAT, 23, 30, 1, 1, 0);
		send_word(OP_ON, 23, 31, 0, 0, 0);
		send_word(OP_NONE, 23, 32, 0, 1, 0);
		send_word(OP_NONE, 10, 0, 1, 0, 0);
		send_word(OP_NONE, 10, 0, 0, 1, 1);
		send_word(OP_HEAT, 8, 30, 0, 0, 0);
		send_word(OP_NONE, 24, 59, 0, 0, 0);
		send_word(OP_ON, 0, 0, 0, 0, 1);

		for (p = 0; p < 8; p++) begin
			drain();
			cfg = pick_config(p);
			load_config(cfg);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			for (i = 0; i < 130; i++) begin
				if (p == 2 && i == 65)
					drain();
				random_word(cfg);
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.status_q.size() == 0)
			$display("tb_vent_mode_scheduler: PASS");
		else
			$display("tb_vent_mode_scheduler: FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_vent_mode_scheduler: FAIL");
		$finish;
	end

endmodule
